// ----- hdl/spmx_pkg.sv -----
`default_nettype none
package spmx_pkg;

  // Table sizes (both powers of two)
  localparam int SINE_DEPTH = 256;
  localparam int SINE_LOG   = $clog2(SINE_DEPTH);
  localparam int SINE_KW    = $clog2(SINE_DEPTH + 1);
  localparam int CLIP_LOG   = 10;
  localparam int CLIP_DEPTH = 1 << CLIP_LOG;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Item function codes
  localparam logic [1:0] FUNC_AUDIO = 2'd0;
  localparam logic [1:0] FUNC_PARAM = 2'd1;
  localparam logic [1:0] FUNC_METER = 2'd2;

  // Parameter kinds
  localparam logic [1:0] KIND_GAIN = 2'd0;
  localparam logic [1:0] KIND_PAN  = 2'd1;
  localparam logic [1:0] KIND_MUTE = 2'd2;

  // Clamp limits
  localparam logic signed [16:0] GAIN_MAX = 17'sd32768;
  localparam logic signed [16:0] PAN_MAX  = 17'sd16384;
  localparam logic signed [16:0] PAN_MIN  = -17'sd16384;
  localparam logic signed [16:0] MUTE_THR = 17'sd8192;

  localparam logic signed [28:0] ACC_MAX = 29'sd134217727;
  localparam logic signed [28:0] ACC_MIN = -29'sd134217728;

  localparam logic [15:0] GAIN_RESET  = 16'd16384;
  localparam logic [15:0] DECAY_RESET = 16'd62259;

  typedef enum logic [2:0] {
    OP_AUDIO,
    OP_GAIN,
    OP_PAN,
    OP_MUTE,
    OP_METER
  } op_t;

  // Classified item from the front end
  typedef struct packed {
    op_t                op;
    logic               ch_ok;
    logic [2:0]         channel;
    logic signed [23:0] sample_l;
    logic signed [23:0] sample_r;
    logic               frame_last;
    logic               block_last;
    logic signed [16:0] value;
  } cmd_t;

  // Result record toward the master stage
  typedef struct packed {
    logic               is_meter;
    logic               commit;
    logic signed [27:0] acc_l;
    logic signed [27:0] acc_r;
    logic [24:0]        pk_l;
    logic [24:0]        pk_r;
  } mix_rec_t;

  typedef logic [14:0] sine_tab_t [SINE_DEPTH + 1];
  typedef logic [23:0] clip_tab_t [CLIP_DEPTH + 1];

  // Unsigned long division, used only while building the tables
  function automatic logic [63:0] udiv(logic [63:0] dividend, logic [63:0] divisor);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem  = rem - {1'b0, divisor};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter sine, Q.14, Taylor series in Q30
  function automatic logic [14:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] r;
    x    = (64'(k) * HALF_PI_Q30) >> SINE_LOG;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = udiv((term * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd32768) >> 16;
    return (r > 64'd16384) ? 15'd16384 : r[14:0];
  endfunction

  // exp(-z), z in Q30 within [0,1]
  function automatic logic [63:0] exp_neg(logic [63:0] z);
    logic [63:0] term;
    longint      sum;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int n = 1; n <= 17; n++) begin
      term = udiv((term * z) >> 30, 64'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return 64'(sum);
  endfunction

  // 0.94*tanh(8i/DEPTH) in Q1.23
  function automatic logic [23:0] clip_entry(int unsigned i);
    logic [63:0] z;
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    z = (64'(i) << 30) >> CLIP_LOG;
    u = exp_neg(z);
    for (int s = 0; s < 4; s++) u = (u * u) >> 30;
    num = (Q30_ONE - u) * 64'd94 * (64'd1 << 23);
    den = (Q30_ONE + u) * 64'd100;
    q   = udiv(num + (den >> 1), den);
    return q[23:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int k = 0; k <= SINE_DEPTH; k++) t[k] = sine_entry(k);
    return t;
  endfunction

  function automatic clip_tab_t build_clip();
    clip_tab_t t;
    for (int i = 0; i <= CLIP_DEPTH; i++) t[i] = clip_entry(i);
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam clip_tab_t CLIP_TAB = build_clip();

  localparam logic [15:0] COEFF_RESET = 16'(SINE_TAB[SINE_DEPTH / 2]);

endpackage
`default_nettype wire

// ----- hdl/spmx_in_if.sv -----
`default_nettype none
interface spmx_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         channel;
  logic signed [23:0] sample_left;
  logic signed [23:0] sample_right;
  logic               frame_last;
  logic               block_last;
  logic [1:0]         param_kind;
  logic signed [16:0] param_value;

  modport source (output valid, func, channel, sample_left, sample_right, frame_last,
                  block_last, param_kind, param_value, input ready);
  modport sink (input valid, func, channel, sample_left, sample_right, frame_last,
                block_last, param_kind, param_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/spmx_out_if.sv -----
`default_nettype none
interface spmx_out_if;
  logic               valid;
  logic               ready;
  logic               is_meter;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic [24:0]        peak_left;
  logic [24:0]        peak_right;

  modport source (output valid, is_meter, out_left, out_right, peak_left, peak_right,
                  input ready);
  modport sink (input valid, is_meter, out_left, out_right, peak_left, peak_right,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/spmx_front.sv -----
`default_nettype none
module spmx_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  spmx_in_if.sink        in_if,
  output logic           cmd_valid,
  output spmx_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  spmx_pkg::cmd_t     q_r [QDEPTH];
  logic [PW-1:0]      wp_r, rp_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  spmx_pkg::cmd_t     cin;
  logic               keep;
  logic               ch_ok;
  logic               push;
  logic signed [16:0] v;

  // Classify and clamp the incoming item
  always_comb begin
    v     = in_if.param_value;
    ch_ok = 32'(in_if.channel) < NUM_CHANNELS;
    keep  = 1'b0;
    cin   = '0;
    cin.op         = spmx_pkg::OP_AUDIO;
    cin.ch_ok      = ch_ok;
    cin.channel    = in_if.channel;
    cin.sample_l   = in_if.sample_left;
    cin.sample_r   = in_if.sample_right;
    cin.frame_last = in_if.frame_last;
    cin.block_last = in_if.block_last;
    unique case (in_if.func)
      spmx_pkg::FUNC_AUDIO: begin
        keep = 1'b1;
      end
      spmx_pkg::FUNC_PARAM: begin
        unique case (in_if.param_kind)
          spmx_pkg::KIND_GAIN: begin
            keep   = ch_ok;
            cin.op = spmx_pkg::OP_GAIN;
            if (v < 0)                          cin.value = '0;
            else if (v > spmx_pkg::GAIN_MAX)    cin.value = spmx_pkg::GAIN_MAX;
            else                                cin.value = v;
          end
          spmx_pkg::KIND_PAN: begin
            keep   = ch_ok;
            cin.op = spmx_pkg::OP_PAN;
            if (v < spmx_pkg::PAN_MIN)          cin.value = spmx_pkg::PAN_MIN;
            else if (v > spmx_pkg::PAN_MAX)     cin.value = spmx_pkg::PAN_MAX;
            else                                cin.value = v;
          end
          spmx_pkg::KIND_MUTE: begin
            keep      = ch_ok;
            cin.op    = spmx_pkg::OP_MUTE;
            cin.value = (v > spmx_pkg::MUTE_THR) ? 17'sd1 : 17'sd0;
          end
          default: keep = 1'b0;
        endcase
      end
      spmx_pkg::FUNC_METER: begin
        keep   = 1'b1;
        cin.op = spmx_pkg::OP_METER;
      end
      default: keep = 1'b0;
    endcase
  end

  // Short queue toward the back end; ignored items are taken and dropped
  assign in_if.ready = (cnt_r != CW'(QDEPTH));
  assign push        = in_if.valid && in_if.ready && keep;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !cmd_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && cmd_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)    wp_r <= wp_r + 1'b1;
      if (cmd_pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cin;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- hdl/spmx_exec.sv -----
`default_nettype none
module spmx_exec #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  spmx_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               adv,
  input  logic [15:0]        peak_decay,
  output logic               rec_valid,
  output spmx_pkg::mix_rec_t rec
);

  // Only channels reachable by the 3-bit field get storage
  localparam int NST = (NUM_CHANNELS > 8) ? 8 : NUM_CHANNELS;
  localparam int IW  = (NST > 1) ? $clog2(NST) : 1;
  localparam int KW  = spmx_pkg::SINE_KW;

  logic [15:0]        gain_r [NST];
  logic signed [15:0] pan_r  [NST];
  logic               mute_r [NST];
  logic [15:0]        lc_r   [NST];
  logic [15:0]        rc_r   [NST];
  logic [24:0]        hl_r   [NST];
  logic [24:0]        hr_r   [NST];
  logic [24:0]        bkl_r  [NST];
  logic [24:0]        bkr_r  [NST];
  logic signed [27:0] accl_r, accr_r, accl_nxt, accr_nxt;
  logic               rec_valid_r;
  spmx_pkg::mix_rec_t rec_r, rec_nxt;
  logic               emit;

  logic [IW-1:0]      idx;
  logic [15:0]        g_new;
  logic signed [15:0] p_new;
  logic signed [16:0] pan_sum;
  logic [31:0]        k_raw;
  logic [KW-1:0]      k;
  logic [31:0]        lprod, rprod;
  logic [15:0]        lc_nxt, rc_nxt;

  logic [23:0]        magl, magr;
  logic [39:0]        pl, pr;
  logic [24:0]        ml, mr;
  logic signed [25:0] wl, wr;
  logic signed [28:0] suml, sumr;
  logic signed [27:0] satl, satr;
  logic [24:0]        bkl_nxt, bkr_nxt;
  logic [40:0]        dlp, drp;
  logic [24:0]        dl, dr;
  logic [24:0]        hl_nxt, hr_nxt;
  logic               mix_on;
  logic               do_commit;

  assign cmd_pop = cmd_valid && adv;
  assign idx     = cmd.channel[IW-1:0];

  // Pan/gain coefficient recompute
  always_comb begin
    g_new = gain_r[idx];
    p_new = pan_r[idx];
    if (cmd.op == spmx_pkg::OP_GAIN) g_new = cmd.value[15:0];
    if (cmd.op == spmx_pkg::OP_PAN)  p_new = cmd.value[15:0];
    pan_sum = {p_new[15], p_new} + 17'sd16384;
    k_raw   = (32'(pan_sum[15:0]) * 32'(spmx_pkg::SINE_DEPTH) + 32'd16384) >> 15;
    k       = (k_raw > 32'(spmx_pkg::SINE_DEPTH)) ? KW'(spmx_pkg::SINE_DEPTH)
                                                  : k_raw[KW-1:0];
    lprod   = 32'(g_new) * 32'(spmx_pkg::SINE_TAB[KW'(spmx_pkg::SINE_DEPTH) - k]);
    rprod   = 32'(g_new) * 32'(spmx_pkg::SINE_TAB[k]);
    lc_nxt  = 16'((lprod + 32'd8192) >> 14);
    rc_nxt  = 16'((rprod + 32'd8192) >> 14);
  end

  // Scale, accumulate with saturation, channel meters
  always_comb begin
    magl = cmd.sample_l[23] ? 24'(-cmd.sample_l) : cmd.sample_l;
    magr = cmd.sample_r[23] ? 24'(-cmd.sample_r) : cmd.sample_r;
    pl   = 40'(magl) * 40'(lc_r[idx]);
    pr   = 40'(magr) * 40'(rc_r[idx]);
    ml   = 25'((pl + 40'd8192) >> 14);
    mr   = 25'((pr + 40'd8192) >> 14);
    wl   = cmd.sample_l[23] ? -$signed({1'b0, ml}) : $signed({1'b0, ml});
    wr   = cmd.sample_r[23] ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
    suml = {accl_r[27], accl_r} + {{3{wl[25]}}, wl};
    sumr = {accr_r[27], accr_r} + {{3{wr[25]}}, wr};
    if (suml > spmx_pkg::ACC_MAX)      satl = spmx_pkg::ACC_MAX[27:0];
    else if (suml < spmx_pkg::ACC_MIN) satl = spmx_pkg::ACC_MIN[27:0];
    else                               satl = suml[27:0];
    if (sumr > spmx_pkg::ACC_MAX)      satr = spmx_pkg::ACC_MAX[27:0];
    else if (sumr < spmx_pkg::ACC_MIN) satr = spmx_pkg::ACC_MIN[27:0];
    else                               satr = sumr[27:0];

    mix_on    = (cmd.op == spmx_pkg::OP_AUDIO) && cmd.ch_ok && !mute_r[idx];
    do_commit = (cmd.op == spmx_pkg::OP_AUDIO) && cmd.ch_ok && cmd.block_last;

    bkl_nxt = bkl_r[idx];
    bkr_nxt = bkr_r[idx];
    if (mix_on && ml > bkl_r[idx]) bkl_nxt = ml;
    if (mix_on && mr > bkr_r[idx]) bkr_nxt = mr;

    dlp    = 41'(hl_r[idx]) * 41'(peak_decay);
    drp    = 41'(hr_r[idx]) * 41'(peak_decay);
    dl     = dlp[40:16];
    dr     = drp[40:16];
    hl_nxt = (dl > bkl_nxt) ? dl : bkl_nxt;
    hr_nxt = (dr > bkr_nxt) ? dr : bkr_nxt;
  end

  // Result record and accumulator next state
  always_comb begin
    accl_nxt = accl_r;
    accr_nxt = accr_r;
    emit     = 1'b0;
    rec_nxt  = '0;
    unique case (cmd.op)
      spmx_pkg::OP_AUDIO: begin
        if (mix_on) begin
          accl_nxt = satl;
          accr_nxt = satr;
        end
        if (cmd.frame_last) begin
          emit           = 1'b1;
          rec_nxt.commit = cmd.block_last;
          rec_nxt.acc_l  = accl_nxt;
          rec_nxt.acc_r  = accr_nxt;
          accl_nxt       = '0;
          accr_nxt       = '0;
        end
      end
      spmx_pkg::OP_METER: begin
        emit             = 1'b1;
        rec_nxt.is_meter = 1'b1;
        rec_nxt.pk_l     = cmd.ch_ok ? hl_r[idx] : '0;
        rec_nxt.pk_r     = cmd.ch_ok ? hr_r[idx] : '0;
      end
      spmx_pkg::OP_GAIN, spmx_pkg::OP_PAN, spmx_pkg::OP_MUTE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NST; c++) begin
        gain_r[c] <= spmx_pkg::GAIN_RESET;
        pan_r[c]  <= '0;
        mute_r[c] <= 1'b0;
        lc_r[c]   <= spmx_pkg::COEFF_RESET;
        rc_r[c]   <= spmx_pkg::COEFF_RESET;
        hl_r[c]   <= '0;
        hr_r[c]   <= '0;
        bkl_r[c]  <= '0;
        bkr_r[c]  <= '0;
      end
      accl_r      <= '0;
      accr_r      <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      if (adv) rec_valid_r <= cmd_pop && emit;
      if (cmd_pop) begin
        accl_r <= accl_nxt;
        accr_r <= accr_nxt;
        if (cmd.op == spmx_pkg::OP_GAIN || cmd.op == spmx_pkg::OP_PAN) begin
          gain_r[idx] <= g_new;
          pan_r[idx]  <= p_new;
          lc_r[idx]   <= lc_nxt;
          rc_r[idx]   <= rc_nxt;
        end
        if (cmd.op == spmx_pkg::OP_MUTE) mute_r[idx] <= cmd.value[0];
        if (do_commit) begin
          hl_r[idx]  <= hl_nxt;
          hr_r[idx]  <= hr_nxt;
          bkl_r[idx] <= '0;
          bkr_r[idx] <= '0;
        end else if (cmd.op == spmx_pkg::OP_AUDIO && cmd.ch_ok) begin
          bkl_r[idx] <= bkl_nxt;
          bkr_r[idx] <= bkr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rec_r <= rec_nxt;
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  a_coeff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r[0] <= 16'd32768 && rc_r[0] <= 16'd32768)
    else $error("pan coefficient above unity gain range");

endmodule
`default_nettype wire

// ----- hdl/spmx_master.sv -----
`default_nettype none
module spmx_master (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  spmx_pkg::mix_rec_t rec,
  input  logic [15:0]        peak_decay,
  output logic               adv,
  spmx_out_if.source         out_if
);

  localparam int CL = spmx_pkg::CLIP_LOG;
  localparam int FB = 26 - CL;

  // Stage 1: table lookup
  logic               s1_valid_r, s1_meter_r, s1_commit_r;
  logic [24:0]        s1_pkl_r, s1_pkr_r;
  logic               s1_neg_r [2];
  logic [23:0]        s1_e0_r  [2];
  logic [23:0]        s1_d_r   [2];
  logic [25:0]        s1_f_r   [2];
  logic               neg_nxt  [2];
  logic [23:0]        e0_nxt   [2];
  logic [23:0]        d_nxt    [2];
  logic [25:0]        f_nxt    [2];

  // Stage 2: interpolation product
  logic               s2_valid_r, s2_meter_r, s2_commit_r;
  logic [24:0]        s2_pkl_r, s2_pkr_r;
  logic               s2_neg_r  [2];
  logic [23:0]        s2_e0_r   [2];
  logic [49:0]        s2_prod_r [2];

  // Stage 3: output register and master meters
  logic               out_valid_r, out_meter_r;
  logic signed [23:0] out_l_r, out_r_r;
  logic [24:0]        out_pkl_r, out_pkr_r;
  logic [23:0]        mheld_r [2];
  logic [23:0]        mblk_r  [2];
  logic [23:0]        e_v      [2];
  logic signed [23:0] o_v      [2];
  logic [23:0]        blk_nxt  [2];
  logic [23:0]        held_nxt [2];
  logic [39:0]        dprod    [2];
  logic [23:0]        dd       [2];

  assign adv = !out_valid_r || out_if.ready;

  // Magnitude, table index and fraction
  always_comb begin
    logic signed [27:0] acc;
    logic [27:0]        a;
    logic               big;
    logic [CL:0]        ci;
    logic [CL:0]        ci1;
    logic [23:0]        e1;
    for (int j = 0; j < 2; j++) begin
      acc        = (j == 0) ? rec.acc_l : rec.acc_r;
      neg_nxt[j] = acc[27];
      a          = acc[27] ? 28'(-acc) : acc;
      big        = a[27] | a[26];
      ci         = {1'b0, a[25 -: CL]};
      ci1        = ci + 1'b1;
      if (big) begin
        e0_nxt[j] = spmx_pkg::CLIP_TAB[spmx_pkg::CLIP_DEPTH];
        e1        = spmx_pkg::CLIP_TAB[spmx_pkg::CLIP_DEPTH];
        f_nxt[j]  = '0;
      end else begin
        e0_nxt[j] = spmx_pkg::CLIP_TAB[ci];
        e1        = spmx_pkg::CLIP_TAB[ci1];
        f_nxt[j]  = {a[FB-1:0], {CL{1'b0}}};
      end
      if (e1 < e0_nxt[j]) e1 = e0_nxt[j];
      d_nxt[j] = e1 - e0_nxt[j];
    end
  end

  // Interpolate, restore sign, update master meters
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      e_v[j]      = s2_e0_r[j] + 24'((s2_prod_r[j] + 50'd33554432) >> 26);
      o_v[j]      = s2_neg_r[j] ? -$signed(e_v[j]) : $signed(e_v[j]);
      blk_nxt[j]  = (e_v[j] > mblk_r[j]) ? e_v[j] : mblk_r[j];
      dprod[j]    = 40'(mheld_r[j]) * 40'(peak_decay);
      dd[j]       = dprod[j][39:16];
      held_nxt[j] = (dd[j] > blk_nxt[j]) ? dd[j] : blk_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < 2; j++) begin
        mheld_r[j] <= '0;
        mblk_r[j]  <= '0;
      end
    end else if (adv) begin
      s1_valid_r  <= rec_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (s2_valid_r && !s2_meter_r) begin
        for (int j = 0; j < 2; j++) begin
          mblk_r[j] <= s2_commit_r ? '0 : blk_nxt[j];
          if (s2_commit_r) mheld_r[j] <= held_nxt[j];
        end
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meter_r  <= rec.is_meter;
      s1_commit_r <= rec.commit;
      s1_pkl_r    <= rec.pk_l;
      s1_pkr_r    <= rec.pk_r;
      s2_meter_r  <= s1_meter_r;
      s2_commit_r <= s1_commit_r;
      s2_pkl_r    <= s1_pkl_r;
      s2_pkr_r    <= s1_pkr_r;
      for (int j = 0; j < 2; j++) begin
        s1_neg_r[j]  <= neg_nxt[j];
        s1_e0_r[j]   <= e0_nxt[j];
        s1_d_r[j]    <= d_nxt[j];
        s1_f_r[j]    <= f_nxt[j];
        s2_neg_r[j]  <= s1_neg_r[j];
        s2_e0_r[j]   <= s1_e0_r[j];
        s2_prod_r[j] <= 50'(s1_d_r[j]) * 50'(s1_f_r[j]);
      end
      out_meter_r <= s2_meter_r;
      if (s2_meter_r) begin
        out_l_r   <= '0;
        out_r_r   <= '0;
        out_pkl_r <= s2_pkl_r;
        out_pkr_r <= s2_pkr_r;
      end else begin
        out_l_r   <= o_v[0];
        out_r_r   <= o_v[1];
        out_pkl_r <= {1'b0, s2_commit_r ? held_nxt[0] : mheld_r[0]};
        out_pkr_r <= {1'b0, s2_commit_r ? held_nxt[1] : mheld_r[1]};
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.is_meter   = out_meter_r;
  assign out_if.out_left   = out_l_r;
  assign out_if.out_right  = out_r_r;
  assign out_if.peak_left  = out_pkl_r;
  assign out_if.peak_right = out_pkr_r;

  a_meter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_meter_r |-> out_l_r == 24'sd0 && out_r_r == 24'sd0)
    else $error("meter answer carries audio");

  a_master_peak: assert property (@(posedge clk) disable iff (!rst_n)
    mheld_r[0] <= spmx_pkg::CLIP_TAB[spmx_pkg::CLIP_DEPTH] &&
    mheld_r[1] <= spmx_pkg::CLIP_TAB[spmx_pkg::CLIP_DEPTH])
    else $error("master held peak above clip ceiling");

endmodule
`default_nettype wire

// ----- hdl/stereo_mixer_pan_limiter_meter_unit.sv -----
`default_nettype none
// A result passes the queue, mix stage, clip table lookup, interpolation multiply
// and output register after its item is accepted.
// Throughput: one item, one mix update per cycle while out_if is not stalled.
// Ignored items are accepted and dropped at the front end with no result.
// Reset (synchronous, rst_n low): unity gain, centre pan, unmuted, meters and
// accumulators zero, peak_decay 62259, queue and pipeline empty.
module stereo_mixer_pan_limiter_meter_unit #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  spmx_in_if.sink     in_if,
  spmx_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]        peak_decay_r;
  logic               cmd_valid;
  spmx_pkg::cmd_t     cmd;
  logic               cmd_pop;
  logic               adv;
  logic               rec_valid;
  spmx_pkg::mix_rec_t rec;

  // Decay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_decay_r <= spmx_pkg::DECAY_RESET;
    end else if (cfg_we) begin
      peak_decay_r <= cfg_wdata;
    end
  end

  spmx_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  spmx_exec #(.NUM_CHANNELS(NUM_CHANNELS)) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .adv        (adv),
    .peak_decay (peak_decay_r),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  spmx_master u_master (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .peak_decay (peak_decay_r),
    .adv        (adv),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

// ----- tb/sv/stereo_mixer_pan_limiter_meter_unit_tb.sv -----
`default_nettype none
module stereo_mixer_pan_limiter_meter_unit_tb;

  localparam logic [1:0] FUNC_AUDIO  = spmx_pkg::FUNC_AUDIO;
  localparam logic [1:0] FUNC_PARAM  = spmx_pkg::FUNC_PARAM;
  localparam logic [1:0] FUNC_METER  = spmx_pkg::FUNC_METER;
  localparam logic [1:0] KIND_GAIN   = spmx_pkg::KIND_GAIN;
  localparam logic [1:0] KIND_PAN    = spmx_pkg::KIND_PAN;
  localparam logic [1:0] KIND_MUTE   = spmx_pkg::KIND_MUTE;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NCH = 8;
  localparam int SDEP = 256;
  localparam int CDEP = 1024;
  localparam int SETTLE = 8;

  // how a stimulus row gets its expectation
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_mode_t;

  typedef struct packed {
    logic               is_meter;
    logic signed [23:0] out_l;
    logic signed [23:0] out_r;
    logic [24:0]        pk_l;
    logic [24:0]        pk_r;
  } mix_result_t;

  typedef struct {
    logic [1:0]         func;
    logic [2:0]         ch;
    logic signed [23:0] sl;
    logic signed [23:0] sr;
    logic               fl;
    logic               bl;
    logic [1:0]         kind;
    logic signed [16:0] val;
    row_mode_t          mode;
    mix_result_t        res;
  } mix_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  spmx_in_if  in_bus ();
  spmx_out_if out_bus ();

  stereo_mixer_pan_limiter_meter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_bus),
    .out_if   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mixer model state
  longint sine_lut [SDEP + 1];
  longint clip_lut [CDEP + 1];
  longint gain_q14 [NCH];
  longint pan_q14 [NCH];
  bit     muted [NCH];
  longint coeff_l [NCH];
  longint coeff_r [NCH];
  longint ch_held [2 * NCH];
  longint ch_blk [2 * NCH];
  longint acc [2];
  longint mst_held [2];
  longint mst_blk [2];
  longint decay;

  mix_result_t pending_results [$];
  int errors = 0;
  bit no_idle = 1'b0;
  row_mode_t cur_mode;
  mix_result_t cur_res;

  // append one expected result at the tail
  function automatic void queue_result(mix_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // quarter sine, Q.14, series in Q30
  function automatic longint sine_q14(int k);
    logic [63:0] x, x2, term, r;
    longint sum;
    x = (64'(k) * 64'd1686629713) / SDEP;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd32768) >> 16;
    return (r > 16384) ? 16384 : longint'(r);
  endfunction

  // 0.94*tanh(8i/depth), Q1.23
  function automatic longint tanh_q23(int i);
    logic [63:0] one, z, term, u, num, den;
    longint sum;
    one = 64'd1 << 30;
    z = (64'(i) << 30) / CDEP;
    term = one;
    sum = longint'(one);
    for (int n = 1; n <= 17; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(one)) sum = longint'(one);
    u = 64'(sum);
    for (int s = 0; s < 4; s++) u = (u * u) >> 30;
    num = (one - u) * 64'd94 * (64'd1 << 23);
    den = (one + u) * 64'd100;
    return longint'((num + den / 2) / den);
  endfunction

  function automatic void refresh_coeffs(int c);
    longint k;
    k = ((pan_q14[c] + 16384) * SDEP + 16384) >>> 15;
    if (k > SDEP) k = SDEP;
    coeff_l[c] = (gain_q14[c] * sine_lut[SDEP - k] + 8192) >>> 14;
    coeff_r[c] = (gain_q14[c] * sine_lut[k] + 8192) >>> 14;
  endfunction

  function automatic longint wet(longint s, longint cf);
    longint m;
    m = ((s < 0 ? -s : s) * cf + 8192) >>> 14;
    return s < 0 ? -m : m;
  endfunction

  function automatic longint sat_acc(longint s);
    if (s > 134217727) return 134217727;
    if (s < -134217728) return -134217728;
    return s;
  endfunction

  function automatic longint soft_clip(longint a0);
    longint a, pos, i, f, e, e0, e1;
    a = a0 < 0 ? -a0 : a0;
    if (a >= (longint'(1) << 26)) e = clip_lut[CDEP];
    else begin
      pos = a * CDEP;
      i = pos >>> 26;
      f = pos & ((longint'(1) << 26) - 1);
      e0 = clip_lut[i];
      e1 = clip_lut[i + 1];
      if (e1 < e0) e1 = e0;
      e = e0 + (((e1 - e0) * f + (longint'(1) << 25)) >>> 26);
    end
    return a0 < 0 ? -e : e;
  endfunction

  function automatic longint decayed_peak(longint held, longint blk);
    longint d;
    d = (held * decay) >>> 16;
    return d > blk ? d : blk;
  endfunction

  function automatic void mixer_reset();
    for (int k = 0; k <= SDEP; k++) sine_lut[k] = sine_q14(k);
    for (int i = 0; i <= CDEP; i++) clip_lut[i] = tanh_q23(i);
    decay = 62259;
    for (int c = 0; c < NCH; c++) begin
      gain_q14[c] = 16384;
      pan_q14[c] = 0;
      muted[c] = 0;
      refresh_coeffs(c);
    end
    for (int b = 0; b < 2 * NCH; b++) begin
      ch_held[b] = 0;
      ch_blk[b] = 0;
    end
    for (int s = 0; s < 2; s++) begin
      acc[s] = 0;
      mst_held[s] = 0;
      mst_blk[s] = 0;
    end
  endfunction

  // advance the mixer model by one item; returns 1 when a result is due
  function automatic bit mixer_step(mix_item_t it, output mix_result_t r);
    longint v, wl, wr, ol, orr;
    int c, b;
    c = it.ch;
    b = 2 * c;
    v = it.val;
    r = '0;
    case (it.func)
      FUNC_PARAM: begin
        if (it.kind == KIND_GAIN) begin
          gain_q14[c] = v < 0 ? 0 : (v > 32768 ? 32768 : v);
          refresh_coeffs(c);
        end else if (it.kind == KIND_PAN) begin
          pan_q14[c] = v < -16384 ? -16384 : (v > 16384 ? 16384 : v);
          refresh_coeffs(c);
        end else if (it.kind == KIND_MUTE) begin
          muted[c] = v > 8192;
        end
        return 0;
      end
      FUNC_METER: begin
        r.is_meter = 1'b1;
        r.pk_l = 25'(ch_held[b]);
        r.pk_r = 25'(ch_held[b + 1]);
        return 1;
      end
      FUNC_AUDIO: begin
        if (!muted[c]) begin
          wl = wet(longint'(it.sl), coeff_l[c]);
          wr = wet(longint'(it.sr), coeff_r[c]);
          acc[0] = sat_acc(acc[0] + wl);
          acc[1] = sat_acc(acc[1] + wr);
          if ((wl < 0 ? -wl : wl) > ch_blk[b]) ch_blk[b] = wl < 0 ? -wl : wl;
          if ((wr < 0 ? -wr : wr) > ch_blk[b + 1]) ch_blk[b + 1] = wr < 0 ? -wr : wr;
        end
        if (it.bl) begin
          for (int s = 0; s < 2; s++) begin
            ch_held[b + s] = decayed_peak(ch_held[b + s], ch_blk[b + s]);
            ch_blk[b + s] = 0;
          end
        end
        if (!it.fl) return 0;
        ol = soft_clip(acc[0]);
        orr = soft_clip(acc[1]);
        if ((ol < 0 ? -ol : ol) > mst_blk[0]) mst_blk[0] = ol < 0 ? -ol : ol;
        if ((orr < 0 ? -orr : orr) > mst_blk[1]) mst_blk[1] = orr < 0 ? -orr : orr;
        if (it.bl) begin
          for (int s = 0; s < 2; s++) begin
            mst_held[s] = decayed_peak(mst_held[s], mst_blk[s]);
            mst_blk[s] = 0;
          end
        end
        acc[0] = 0;
        acc[1] = 0;
        r.out_l = 24'(ol);
        r.out_r = 24'(orr);
        r.pk_l = 25'(mst_held[0]);
        r.pk_r = 25'(mst_held[1]);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // scoreboard: check results, then predict accepted items
  always @(posedge clk) begin
    mix_item_t it;
    mix_result_t want, got;
    bit due;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.is_meter, out_bus.out_left, out_bus.out_right,
                out_bus.peak_left, out_bus.peak_right};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        it.func = in_bus.func;
        it.ch = in_bus.channel;
        it.sl = in_bus.sample_left;
        it.sr = in_bus.sample_right;
        it.fl = in_bus.frame_last;
        it.bl = in_bus.block_last;
        it.kind = in_bus.param_kind;
        it.val = in_bus.param_value;
        due = mixer_step(it, want);
        if (cur_mode == ROW_TYPED) queue_result(cur_res);
        else if (cur_mode == ROW_PREDICT && due) queue_result(want);
      end
    end
  end

  // result side back-pressure in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || no_idle) out_bus.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_bus.ready <= 1'b0;
    end else out_bus.ready <= 1'b1;
  end

  task automatic send_item(mix_item_t it);
    int gap;
    gap = (!no_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= it.func;
    in_bus.channel <= it.ch;
    in_bus.sample_left <= it.sl;
    in_bus.sample_right <= it.sr;
    in_bus.frame_last <= it.fl;
    in_bus.block_last <= it.bl;
    in_bus.param_kind <= it.kind;
    in_bus.param_value <= it.val;
    cur_mode <= it.mode;
    cur_res <= it.res;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // let the block go idle with nothing outstanding
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_decay(logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    decay = d;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(signed'($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [16:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 17'sh0FFFF;
      1: return 17'sh10000;
      2: return 17'(signed'($urandom_range(0, 32768)));
      3: return 17'(signed'($urandom_range(0, 32768)) - 16384);
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic mix_item_t make_item(logic [1:0] f, logic [2:0] c, logic signed [23:0] l,
                                          logic signed [23:0] r, logic fl, logic bl,
                                          logic [1:0] k, logic signed [16:0] v,
                                          row_mode_t m = ROW_PREDICT,
                                          mix_result_t res = '0);
    mix_item_t it;
    it = '{f, c, l, r, fl, bl, k, v, m, res};
    return it;
  endfunction

  // directed rows
  mix_item_t directed [] = '{
    make_item(FUNC_METER, 3'd0, 0, 0, 0, 0, KIND_GAIN, 0, ROW_TYPED, '{1, 0, 0, 0, 0}),
    make_item(FUNC_METER, 3'd7, 0, 0, 0, 0, KIND_GAIN, 0, ROW_TYPED, '{1, 0, 0, 0, 0}),
    make_item(FUNC_UNUSED, 3'd2, 24'sh7FFFFF, 24'sh7FFFFF, 1, 1, KIND_GAIN, 0, ROW_SILENT),
    make_item(FUNC_AUDIO, 3'd5, 0, 0, 1, 1, KIND_GAIN, 0, ROW_TYPED, '{0, 0, 0, 0, 0}),
    make_item(FUNC_AUDIO, 3'd0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd1, 24'sh800000, 24'sh800000, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd2, 24'sh400000, 24'shC00000, 1, 1, KIND_GAIN, 0),
    make_item(FUNC_PARAM, 3'd0, 0, 0, 1, 1, KIND_GAIN, 17'sh0FFFF, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd1, 0, 0, 0, 0, KIND_GAIN, 17'sh10000, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd0, 0, 0, 0, 0, KIND_PAN, 17'sh0FFFF, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd4, 0, 0, 0, 0, KIND_PAN, 17'sh10000, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd4, 0, 0, 0, 0, KIND_GAIN, 17'sd32768, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd2, 0, 0, 0, 0, KIND_MUTE, 17'sd8193, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd3, 0, 0, 0, 0, KIND_MUTE, 17'sd8192, ROW_SILENT),
    make_item(FUNC_PARAM, 3'd3, 0, 0, 0, 0, KIND_UNUSED, 17'sd0, ROW_SILENT),
    make_item(FUNC_AUDIO, 3'd0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd4, 24'sh800000, 24'sh800000, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd1, 24'sh7FFFFF, 24'sh800000, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd2, 24'sh7FFFFF, 24'sh7FFFFF, 0, 1, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd3, 24'sh800000, 24'sh7FFFFF, 1, 1, KIND_GAIN, 0),
    make_item(FUNC_METER, 3'd0, 0, 0, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_METER, 3'd2, 0, 0, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_METER, 3'd4, 0, 0, 0, 0, KIND_GAIN, 0),
    make_item(FUNC_AUDIO, 3'd6, 0, 0, 1, 0, KIND_GAIN, 0)
  };

  // one frame with random content, noise items mixed in
  task automatic send_frame(inout int sent);
    int n;
    logic bl;
    mix_item_t it;
    n = $urandom_range(1, 8);
    bl = ($urandom_range(0, 3) == 0);
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 19))
        0, 1: send_item(make_item(FUNC_PARAM, 3'($urandom), pick_sample(), pick_sample(),
                                  1'($urandom), 1'($urandom), 2'($urandom), pick_value()));
        2: send_item(make_item(FUNC_METER, 3'($urandom), pick_sample(), pick_sample(),
                               1'($urandom), 1'($urandom), 2'($urandom), pick_value()));
        3: send_item(make_item(FUNC_UNUSED, 3'($urandom), pick_sample(), pick_sample(),
                               1'($urandom), 1'($urandom), 2'($urandom), pick_value()));
        default: ;
      endcase
      it = make_item(FUNC_AUDIO, 3'($urandom), pick_sample(), pick_sample(), j == n - 1, bl,
                     2'($urandom), pick_value());
      send_item(it);
      sent += 1;
    end
  endtask

  initial begin
    int sent;
    logic [15:0] phase_decay [3] = '{16'hFFFF, 16'h0000, 16'h0000};
    phase_decay[2] = 16'($urandom);
    mixer_reset();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    cur_mode <= ROW_PREDICT;
    cur_res <= '0;
    in_bus.valid <= 1'b0;
    in_bus.func <= FUNC_AUDIO;
    in_bus.channel <= '0;
    in_bus.sample_left <= '0;
    in_bus.sample_right <= '0;
    in_bus.frame_last <= 1'b0;
    in_bus.block_last <= 1'b0;
    in_bus.param_kind <= KIND_GAIN;
    in_bus.param_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);

    // four phases of random frames, decay changed between them
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        write_decay(phase == 3 ? 16'd62259 : phase_decay[phase - 1]);
        if (phase == 2) write_decay(16'hFFFF);
        if (phase == 2) write_decay(phase_decay[phase - 1]);
      end
      no_idle = (phase == 3);
      sent = 0;
      while (sent < 390) send_frame(sent);
    end
    drain();
    if (errors == 0 && pending_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
